/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ucfr_pkg.sv */
// ----------------------------------------------------------------------------
// ucfr_pkg
// Types and constants of the command frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] duty_t;
  typedef logic [3:0] nibble_t;

  typedef enum logic [1:0] {
    RegHeaderFirst  = 2'd0,
    RegHeaderSecond = 2'd1,
    RegFrameLength  = 2'd2
  } cfg_index_t;

  localparam byte_t HeaderFirstRst  = 8'hAA;
  localparam byte_t HeaderSecondRst = 8'h88;
  localparam byte_t FrameLengthRst  = 8'd8;

  localparam byte_t PosHeaderFirst  = 8'd0;
  localparam byte_t PosHeaderSecond = 8'd1;
  localparam byte_t PosLength       = 8'd2;
  localparam byte_t PosBody         = 8'd3;
  localparam byte_t PosCommand      = 8'd4;

  localparam nibble_t CmdDutyOff  = 4'h0;
  localparam nibble_t CmdDutyFull = 4'h1;
  localparam nibble_t CmdBreathe  = 4'h2;

  localparam duty_t DutyZero = 7'd0;
  localparam duty_t DutyFull = 7'd100;

  typedef struct packed {
    byte_t header_first;
    byte_t header_second;
    byte_t frame_length;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    logic  checksum_ok;
    duty_t duty_level;
    logic  breathing;
  } res_t;

endpackage

/* rtl/ucfr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ucfr_cfg_regs
// Configuration register file: header bytes and frame length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucfr_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  ucfr_pkg::byte_t       wr_data,
  output ucfr_pkg::cfg_t        cfg
);

  ucfr_pkg::cfg_t cfg_r;
  ucfr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        ucfr_pkg::RegHeaderFirst:  cfg_nxt.header_first  = wr_data;
        ucfr_pkg::RegHeaderSecond: cfg_nxt.header_second = wr_data;
        ucfr_pkg::RegFrameLength:  cfg_nxt.frame_length  = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= ucfr_pkg::HeaderFirstRst;
      cfg_r.header_second <= ucfr_pkg::HeaderSecondRst;
      cfg_r.frame_length  <= ucfr_pkg::FrameLengthRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/ucfr_parser.sv */
// ----------------------------------------------------------------------------
// ucfr_parser
// Frame parse state, running checksum and command decode; one byte a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ucfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  ucfr_pkg::byte_t rx_byte,
  input  ucfr_pkg::cfg_t  cfg,
  output ucfr_pkg::res_t  res
);

  ucfr_pkg::byte_t   pos_r,     pos_nxt;
  ucfr_pkg::byte_t   sum_r,     sum_nxt;
  ucfr_pkg::nibble_t nib_r,     nib_nxt;
  ucfr_pkg::duty_t   duty_r,    duty_nxt;
  logic              breathe_r, breathe_nxt;

  ucfr_pkg::nibble_t nib_eff;
  logic [8:0]        pos_inc;
  ucfr_pkg::byte_t   sum_add;
  ucfr_pkg::byte_t   check;
  logic              ok;

  assign nib_eff = (pos_r == ucfr_pkg::PosCommand) ? rx_byte[3:0] : nib_r;
  assign pos_inc = {1'b0, pos_r} + 9'd1;
  assign sum_add = sum_r + rx_byte;
  assign check   = 8'd0 - sum_r;
  assign ok      = (rx_byte == check);

  always_comb begin
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    nib_nxt     = nib_r;
    duty_nxt    = duty_r;
    breathe_nxt = breathe_r;
    res         = '0;
    if (step) begin
      case (pos_r)
        ucfr_pkg::PosHeaderFirst: begin
          pos_nxt = (rx_byte == cfg.header_first) ? ucfr_pkg::PosHeaderSecond
                                                  : ucfr_pkg::PosHeaderFirst;
          sum_nxt = '0;
        end
        ucfr_pkg::PosHeaderSecond: begin
          if (rx_byte == cfg.header_second) begin
            pos_nxt = ucfr_pkg::PosLength;
            sum_nxt = rx_byte;
          end else begin
            pos_nxt = ucfr_pkg::PosHeaderFirst;
          end
        end
        ucfr_pkg::PosLength: begin
          if (rx_byte == cfg.frame_length) begin
            pos_nxt = ucfr_pkg::PosBody;
            sum_nxt = sum_add;
          end else begin
            pos_nxt = ucfr_pkg::PosHeaderFirst;
          end
        end
        default: begin
          nib_nxt = nib_eff;
          if (pos_inc < {1'b0, cfg.frame_length}) begin
            sum_nxt = sum_add;
            pos_nxt = pos_inc[7:0];
          end else begin
            // check byte: apply command only on a match
            if (ok) begin
              case (nib_eff)
                ucfr_pkg::CmdDutyOff: begin
                  duty_nxt    = ucfr_pkg::DutyZero;
                  breathe_nxt = 1'b0;
                end
                ucfr_pkg::CmdDutyFull: begin
                  duty_nxt    = ucfr_pkg::DutyFull;
                  breathe_nxt = 1'b0;
                end
                ucfr_pkg::CmdBreathe: breathe_nxt = 1'b1;
                default: ;
              endcase
            end
            pos_nxt         = ucfr_pkg::PosHeaderFirst;
            sum_nxt         = '0;
            res.valid       = 1'b1;
            res.checksum_ok = ok;
            res.duty_level  = duty_nxt;
            res.breathing   = breathe_nxt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      sum_r     <= '0;
      nib_r     <= '0;
      duty_r    <= '0;
      breathe_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      nib_r     <= nib_nxt;
      duty_r    <= duty_nxt;
      breathe_r <= breathe_nxt;
    end
  end

  `ASSERT_ALWAYS(a_duty_legal, clk, rst_n,
    (duty_r == ucfr_pkg::DutyZero) || (duty_r == ucfr_pkg::DutyFull),
    "duty holds a value no command sets")
  `ASSERT_IMPL(a_end_in_body, clk, rst_n, res.valid, pos_r >= ucfr_pkg::PosBody,
    "frame end outside frame body")
  `ASSERT_NEXT(a_end_restarts, clk, rst_n, res.valid,
    (pos_r == ucfr_pkg::PosHeaderFirst) && (sum_r == 8'd0),
    "parser did not restart after frame end")

endmodule

/* rtl/uart_command_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// uart_command_frame_receiver_unit
// Parses received bytes into command frames with an additive checksum and
// reports LED duty and breathing mode at each frame end.
// ----------------------------------------------------------------------------
//   channel | direction | word
//   in_     | input     | rx_byte, one received byte
//   out_    | output    | checksum_ok, duty_level, breathing at frame end
//   cfg_    | input     | index 0..2 and 8-bit register data
//
// One byte per cycle while no result waits on out_ready: an input register feeds
// the parser, whose frame-end result lands in an output register; out_valid
// rises once the frame's last byte has passed through both registers.
// A waiting result does not block input until the input register also fills.
// Synchronous active-low reset restores register defaults and clears state.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_command_frame_receiver_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ucfr_pkg::byte_t in_rx_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_checksum_ok,
  output ucfr_pkg::duty_t out_duty_level,
  output logic            out_breathing,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  ucfr_pkg::byte_t cfg_data
);

  ucfr_pkg::cfg_t  cfg;
  ucfr_pkg::res_t  res;

  logic            in_vld_r, in_vld_nxt;
  ucfr_pkg::byte_t in_byte_r;
  logic            out_vld_r, out_vld_nxt;
  logic            out_ok_r;
  ucfr_pkg::duty_t out_duty_r;
  logic            out_breathe_r;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;

  ucfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ucfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (advance) in_vld_nxt = 1'b0;
    if (in_valid && in_ready) in_vld_nxt = 1'b1;
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ready) out_vld_nxt = 1'b0;
    if (res.valid) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
    if (res.valid) begin
      out_ok_r      <= res.checksum_ok;
      out_duty_r    <= res.duty_level;
      out_breathe_r <= res.breathing;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_checksum_ok = out_ok_r;
  assign out_duty_level  = out_duty_r;
  assign out_breathing   = out_breathe_r;

endmodule

/* tb/tb_uart_command_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// tb_uart_command_frame_receiver_unit
// Streams header, length, body and check bytes into the frame receiver under
// several register settings, predicts each frame-end word, and compares it
// field by field, with both channels idling in random bursts in most settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_command_frame_receiver_unit;
  import ucfr_pkg::*;

  typedef struct packed {
    logic  ok;
    duty_t duty;
    logic  breathe;
  } frame_result_t;

  logic   clk;
  logic   rst_n      = 1'b0;
  logic   in_valid   = 1'b0;
  logic   in_ready;
  byte_t  in_rx_byte = '0;
  logic   out_valid;
  logic   out_ready  = 1'b0;
  logic   out_checksum_ok;
  duty_t  out_duty_level;
  logic   out_breathing;
  logic   cfg_valid  = 1'b0;
  logic   cfg_ready;
  logic [1:0] cfg_index = '0;
  byte_t  cfg_data   = '0;

  // register copy and parser state of the predictor
  cfg_t   rx_cfg      = {HeaderFirstRst, HeaderSecondRst, FrameLengthRst};
  byte_t  frm_pos     = '0;
  byte_t  frm_sum     = '0;
  nibble_t frm_cmd    = '0;
  duty_t  led_duty    = DutyZero;
  logic   led_breathe = 1'b0;

  byte_t          rx_byte_q[$];
  frame_result_t  frame_results_q[$];
  int  bytes_queued    = 0;
  int  bytes_accepted  = 0;
  int  frames_seen     = 0;
  int  frames_ok       = 0;
  int  settings_run    = 1;
  int  mismatch_count  = 0;
  int  idle_pct        = 20;
  bit  no_idle         = 1'b0;
  int  in_gap          = 0;
  int  out_stall       = 0;

  uart_command_frame_receiver_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_checksum_ok (out_checksum_ok),
    .out_duty_level  (out_duty_level),
    .out_breathing   (out_breathing),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit parse_rx_byte(input byte_t rx, output frame_result_t res);
    logic [8:0] nxt;
    res = '0;
    case (frm_pos)
      PosHeaderFirst: begin
        frm_pos = (rx == rx_cfg.header_first) ? PosHeaderSecond : PosHeaderFirst;
        frm_sum = '0;
        return 1'b0;
      end
      PosHeaderSecond: begin
        if (rx == rx_cfg.header_second) begin
          frm_pos = PosLength;
          frm_sum = rx;
        end else begin
          frm_pos = PosHeaderFirst;
        end
        return 1'b0;
      end
      PosLength: begin
        if (rx == rx_cfg.frame_length) begin
          frm_pos = PosBody;
          frm_sum = frm_sum + rx;
        end else begin
          frm_pos = PosHeaderFirst;
        end
        return 1'b0;
      end
      default: ;
    endcase
    if (frm_pos == PosCommand) frm_cmd = rx[3:0];
    nxt = {1'b0, frm_pos} + 9'd1;
    if (nxt < {1'b0, rx_cfg.frame_length}) begin
      frm_sum = frm_sum + rx;
      frm_pos = nxt[7:0];
      return 1'b0;
    end
    res.ok = (rx == byte_t'(10'h200 - {2'b00, frm_sum}));
    if (res.ok) begin
      case (frm_cmd)
        CmdDutyOff: begin
          led_duty    = DutyZero;
          led_breathe = 1'b0;
        end
        CmdDutyFull: begin
          led_duty    = DutyFull;
          led_breathe = 1'b0;
        end
        CmdBreathe: led_breathe = 1'b1;
        default: ;
      endcase
    end
    frm_pos     = PosHeaderFirst;
    frm_sum     = '0;
    res.duty    = led_duty;
    res.breathe = led_breathe;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : byte_driver
    frame_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_accepted++;
        if (parse_rx_byte(in_rx_byte, res)) frame_results_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (rx_byte_q.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_byte_q.pop_front();
          if (!no_idle && $urandom_range(99) < idle_pct) in_gap = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        frames_seen++;
        if (out_checksum_ok) frames_ok++;
        if (frame_results_q.size() == 0) begin
          $error("frame result with nothing expected");
          mismatch_count++;
        end else begin
          want = frame_results_q.pop_front();
          if (out_checksum_ok !== want.ok) begin
            $error("checksum_ok: expected %0d, got %0d", want.ok, out_checksum_ok);
            mismatch_count++;
          end
          if (out_duty_level !== want.duty) begin
            $error("duty_level: expected %0d, got %0d", want.duty, out_duty_level);
            mismatch_count++;
          end
          if (out_breathing !== want.breathe) begin
            $error("breathing: expected %0d, got %0d", want.breathe, out_breathing);
            mismatch_count++;
          end
        end
      end
      if (no_idle) begin
        out_stall = 0;
        out_ready <= 1'b1;
      end else if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99) < idle_pct) out_stall = $urandom_range(1, 9);
      end
    end
  end

  task automatic push_byte(input byte_t rx);
    rx_byte_q.push_back(rx);
    bytes_queued++;
  endtask

  // keep < frame size sends a truncated frame
  task automatic add_frame(input bit good, input nibble_t cmd, input int keep);
    byte_t fb[$];
    byte_t sum;
    int n;
    n = (rx_cfg.frame_length < 4) ? 4 : int'(rx_cfg.frame_length);
    fb.push_back(rx_cfg.header_first);
    fb.push_back(rx_cfg.header_second);
    fb.push_back(rx_cfg.frame_length);
    for (int i = 3; i < n; i++) fb.push_back(byte_t'($urandom_range(255)));
    if (n > 5) fb[PosCommand] = {fb[PosCommand][7:4], cmd};
    sum = '0;
    for (int i = 1; i < n - 1; i++) sum = sum + fb[i];
    fb[n-1] = byte_t'(8'd0 - sum);
    if (!good) fb[n-1] = fb[n-1] ^ byte_t'($urandom_range(1, 255));
    for (int i = 0; i < n && i < keep; i++) push_byte(fb[i]);
  endtask

  task automatic add_noise();
    byte_t rx;
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 4)) push_byte(byte_t'($urandom_range(255)));
      1: begin
        push_byte(rx_cfg.header_first);
        rx = $urandom_range(1) ? rx_cfg.header_first : byte_t'($urandom_range(255));
        if (rx == rx_cfg.header_second) rx = rx ^ 8'h01;
        push_byte(rx);
      end
      2: begin
        push_byte(rx_cfg.header_first);
        push_byte(rx_cfg.header_second);
        push_byte(rx_cfg.frame_length ^ byte_t'($urandom_range(1, 255)));
      end
      default: add_frame(1'b1, nibble_t'($urandom_range(15)),
                         $urandom_range(3, int'(rx_cfg.frame_length) - 1));
    endcase
  endtask

  task automatic wait_idle();
    while (bytes_accepted != bytes_queued || frame_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int start;
    nibble_t cmd;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(4))
          0: cmd = CmdDutyOff;
          1: cmd = CmdDutyFull;
          2: cmd = CmdBreathe;
          default: cmd = nibble_t'($urandom_range(15));
        endcase
        add_frame($urandom_range(99) < 85, cmd, 256);
      end else begin
        add_noise();
      end
    end
    wait_idle();
  endtask

  task automatic write_reg(input cfg_index_t idx, input byte_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegHeaderFirst:  rx_cfg.header_first  = val;
      RegHeaderSecond: rx_cfg.header_second = val;
      RegFrameLength:  rx_cfg.frame_length  = val;
      default: ;
    endcase
  endtask

  task automatic set_frame_cfg(input byte_t h1, input byte_t h2, input byte_t len);
    write_reg(RegHeaderFirst, h1);
    write_reg(RegHeaderSecond, h2);
    write_reg(RegFrameLength, len);
    cfg_valid <= 1'b0;
    settings_run++;
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: commands, failed check, repeated header, bad length, byte extremes
    idle_pct = 20;
    add_frame(1'b1, CmdDutyFull, 256);
    add_frame(1'b0, CmdBreathe, 256);
    push_byte(rx_cfg.header_first);
    push_byte(rx_cfg.header_first);
    push_byte(rx_cfg.header_second);
    push_byte(rx_cfg.header_first);
    push_byte(rx_cfg.header_second);
    push_byte(rx_cfg.frame_length - 8'd1);
    push_byte(8'h00);
    push_byte(8'hFF);
    run_random(120);

    idle_pct = 30;
    set_frame_cfg(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), 8'd6);
    run_random(120);

    idle_pct = 10;
    set_frame_cfg(8'h00, 8'hFF, 8'd255);
    run_random(500);

    idle_pct = 0;
    set_frame_cfg(8'hFF, 8'h00, byte_t'($urandom_range(6, 20)));
    run_random(100);

    // short lengths: check byte right after the length byte or at the command slot
    idle_pct = 20;
    set_frame_cfg(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), 8'd5);
    run_random(60);
    set_frame_cfg(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), 8'd4);
    run_random(40);
    set_frame_cfg(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)), 8'd3);
    run_random(40);

    no_idle = 1'b1;
    set_frame_cfg(HeaderFirstRst, HeaderSecondRst, FrameLengthRst);
    run_random(100);

    repeat (8) @(posedge clk);
    $display("covered %0d bytes and %0d frame words (%0d with a matching checksum)",
             bytes_accepted, frames_seen, frames_ok);
    $display("across %0d register settings, frame lengths 3 to 255", settings_run);
    if (mismatch_count == 0 && frame_results_q.size() == 0) begin
      $display("tb_uart_command_frame_receiver_unit passed");
    end else begin
      $display("tb_uart_command_frame_receiver_unit failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_uart_command_frame_receiver_unit failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ucfr_pkg.sv
rtl/ucfr_cfg_regs.sv
rtl/ucfr_parser.sv
rtl/uart_command_frame_receiver_unit.sv
tb/tb_uart_command_frame_receiver_unit.sv
